@@ rtl/ffha_pkg.sv @@
// First-fit heap allocator: shared types, codes and helpers.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int unsigned HEAP_WORDS_DEF = 1024;
    localparam int unsigned HDR_BYTES      = 8;
    localparam int unsigned MIN_LEN        = 16;
    localparam logic [12:0] HEAP_LEN_RST   = 13'd4096;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [12:0] request_size;
        logic [11:0] block_address;
    } t_item;

    typedef struct packed {
        logic        granted;
        logic [11:0] payload_address;
    } t_result;

    typedef enum logic [4:0] {
        ST_FMT_HEAD,
        ST_FMT_SIZE,
        ST_FMT_END,
        ST_FMT_END_SIZE,
        ST_IDLE,
        ST_RD_NEXT,
        ST_RD_SIZE,
        ST_EVAL,
        ST_RUN_SIZE,
        ST_RUN_NEXT,
        ST_SPLIT_USED,
        ST_SPLIT_NEXT,
        ST_TAIL_NEXT,
        ST_TAIL_SIZE,
        ST_FREE_CHK,
        ST_FREE_WR
    } t_state;

    typedef enum logic [3:0] {
        MEM_IDLE,
        MEM_RD_NEXT,
        MEM_RD_SIZE,
        MEM_RD_FREE,
        MEM_WR_FMT_HEAD,
        MEM_WR_FMT_SIZE,
        MEM_WR_FMT_END,
        MEM_WR_FMT_END_SIZE,
        MEM_WR_RUN_SIZE,
        MEM_WR_RUN_NEXT,
        MEM_WR_USED_SIZE,
        MEM_WR_SPLIT_NEXT,
        MEM_WR_TAIL_NEXT,
        MEM_WR_TAIL_SIZE,
        MEM_WR_FREE
    } t_mem_op;

    typedef struct packed {
        t_mem_op mem_op;
        logic    ld_alloc;
        logic    ld_free;
        logic    cap_next;
        logic    advance;
        logic    mark_q;
        logic    set_scan_q;
        logic    clear_scan;
        logic    finish;
        logic    grant;
    } t_dp_cmd;

    typedef struct packed {
        logic next_zero;
        logic used;
        logic guard_fail;
        logic fits;
        logic free_ok;
    } t_dp_sts;

    // Usable length: round up to a word, clamp to [MIN_LEN, cap].
    function automatic logic [31:0] eff_len(input logic [12:0] hl, input logic [31:0] cap);
        logic [31:0] l;
        l = (32'(hl) + 32'd3) & ~32'd3;
        if (l > cap) l = cap;
        if (l < 32'(MIN_LEN)) l = 32'(MIN_LEN);
        return l;
    endfunction

endpackage

@@ rtl/ffha_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffha_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ffha_ctrl.sv @@
// Allocator controller: sequences format, header walk, split and free.
// Depends on ffha_pkg; drives the datapath through t_dp_cmd, reads t_dp_sts.
`timescale 1ns / 1ps

module ffha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_action,
    input  logic              i_cfg_we,
    input  ffha_pkg::t_dp_sts i_sts,
    output ffha_pkg::t_dp_cmd o_cmd,
    output logic              o_busy
);

    ffha_pkg::t_state r_state, n_state;
    logic             r_merge, n_merge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::ST_FMT_HEAD;
            r_merge <= 1'b0;
        end else begin
            r_state <= n_state;
            r_merge <= n_merge;
        end
    end

    always_comb begin
        n_state = r_state;
        n_merge = r_merge;
        o_cmd   = '0;
        o_cmd.mem_op = ffha_pkg::MEM_IDLE;
        unique case (r_state)
            ffha_pkg::ST_FMT_HEAD: begin
                o_cmd.mem_op = ffha_pkg::MEM_WR_FMT_HEAD;
                n_state = ffha_pkg::ST_FMT_SIZE;
            end
            ffha_pkg::ST_FMT_SIZE: begin
                o_cmd.mem_op = ffha_pkg::MEM_WR_FMT_SIZE;
                n_state = ffha_pkg::ST_FMT_END;
            end
            ffha_pkg::ST_FMT_END: begin
                o_cmd.mem_op = ffha_pkg::MEM_WR_FMT_END;
                n_state = ffha_pkg::ST_FMT_END_SIZE;
            end
            ffha_pkg::ST_FMT_END_SIZE: begin
                o_cmd.mem_op = ffha_pkg::MEM_WR_FMT_END_SIZE;
                o_cmd.clear_scan = 1'b1;
                n_state = ffha_pkg::ST_IDLE;
            end
            ffha_pkg::ST_IDLE: begin
                n_merge = 1'b0;
                priority if (i_cfg_we) begin
                    n_state = ffha_pkg::ST_FMT_HEAD;
                end else if (i_start) begin
                    if (i_action == ffha_pkg::ACT_FREE) begin
                        o_cmd.ld_free = 1'b1;
                        n_state = ffha_pkg::ST_FREE_CHK;
                    end else begin
                        o_cmd.ld_alloc = 1'b1;
                        n_state = ffha_pkg::ST_RD_NEXT;
                    end
                end else begin
                    n_state = ffha_pkg::ST_IDLE;
                end
            end
            ffha_pkg::ST_RD_NEXT: begin
                o_cmd.mem_op = ffha_pkg::MEM_RD_NEXT;
                n_state = ffha_pkg::ST_RD_SIZE;
            end
            ffha_pkg::ST_RD_SIZE: begin
                o_cmd.mem_op = ffha_pkg::MEM_RD_SIZE;
                o_cmd.cap_next = 1'b1;
                n_state = ffha_pkg::ST_EVAL;
            end
            ffha_pkg::ST_EVAL: begin
                if (!r_merge) begin
                    // skip used blocks; a free block opens a run
                    if (i_sts.next_zero || i_sts.guard_fail) begin
                        o_cmd.finish = 1'b1;
                        n_state = ffha_pkg::ST_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        if (!i_sts.used) begin
                            o_cmd.mark_q = 1'b1;
                            n_merge = 1'b1;
                        end
                        n_state = ffha_pkg::ST_RD_NEXT;
                    end
                end else begin
                    priority if (i_sts.used || i_sts.next_zero) begin
                        n_state = i_sts.fits ? ffha_pkg::ST_SPLIT_USED
                                             : ffha_pkg::ST_RUN_SIZE;
                    end else if (i_sts.guard_fail) begin
                        o_cmd.finish = 1'b1;
                        n_state = ffha_pkg::ST_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state = ffha_pkg::ST_RD_NEXT;
                    end
                end
            end
            ffha_pkg::ST_RUN_SIZE: begin
                o_cmd.mem_op = ffha_pkg::MEM_WR_RUN_SIZE;
                n_state = ffha_pkg::ST_RUN_NEXT;
            end
            ffha_pkg::ST_RUN_NEXT: begin
                // run too small: keep the merged block, clear the merge flag, resume skipping at the run end
                o_cmd.mem_op = ffha_pkg::MEM_WR_RUN_NEXT;
                n_merge = 1'b0;
                n_state = ffha_pkg::ST_RD_NEXT;
            end
            ffha_pkg::ST_SPLIT_USED: begin
                o_cmd.mem_op = ffha_pkg::MEM_WR_USED_SIZE;
                n_state = ffha_pkg::ST_SPLIT_NEXT;
            end
            ffha_pkg::ST_SPLIT_NEXT: begin
                o_cmd.mem_op = ffha_pkg::MEM_WR_SPLIT_NEXT;
                n_state = ffha_pkg::ST_TAIL_NEXT;
            end
            ffha_pkg::ST_TAIL_NEXT: begin
                o_cmd.mem_op = ffha_pkg::MEM_WR_TAIL_NEXT;
                n_state = ffha_pkg::ST_TAIL_SIZE;
            end
            ffha_pkg::ST_TAIL_SIZE: begin
                o_cmd.mem_op = ffha_pkg::MEM_WR_TAIL_SIZE;
                o_cmd.set_scan_q = 1'b1;
                o_cmd.finish = 1'b1;
                o_cmd.grant = 1'b1;
                n_state = ffha_pkg::ST_IDLE;
            end
            ffha_pkg::ST_FREE_CHK: begin
                if (i_sts.free_ok) begin
                    o_cmd.mem_op = ffha_pkg::MEM_RD_FREE;
                    n_state = ffha_pkg::ST_FREE_WR;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state = ffha_pkg::ST_IDLE;
                end
            end
            ffha_pkg::ST_FREE_WR: begin
                o_cmd.mem_op = ffha_pkg::MEM_WR_FREE;
                o_cmd.clear_scan = 1'b1;
                o_cmd.finish = 1'b1;
                o_cmd.grant = 1'b1;
                n_state = ffha_pkg::ST_IDLE;
            end
            default: begin
                n_state = ffha_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ffha_pkg::ST_IDLE);

`ifndef SYNTHESIS
    a_merge_only_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_merge |-> (r_state == ffha_pkg::ST_RD_NEXT || r_state == ffha_pkg::ST_RD_SIZE ||
                     r_state == ffha_pkg::ST_EVAL || r_state == ffha_pkg::ST_RUN_SIZE ||
                     r_state == ffha_pkg::ST_RUN_NEXT || r_state == ffha_pkg::ST_SPLIT_USED ||
                     r_state == ffha_pkg::ST_SPLIT_NEXT || r_state == ffha_pkg::ST_TAIL_NEXT ||
                     r_state == ffha_pkg::ST_TAIL_SIZE || r_state == ffha_pkg::ST_IDLE))
        else $error("merge flag set outside the header walk");
    a_finish_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == ffha_pkg::ST_IDLE))
        else $error("item finished but controller did not return to idle");
    a_grant_with_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.grant |-> o_cmd.finish)
        else $error("grant raised outside the last state of an item");
`endif

endmodule

@@ rtl/ffha_dpath.sv @@
// Allocator datapath: walk pointers, scan start, length register and heap RAM.
// Depends on ffha_pkg and ffha_ram; steered by t_dp_cmd from ffha_ctrl.
`timescale 1ns / 1ps

module ffha_dpath #(
    parameter int unsigned HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffha_pkg::t_item   i_item,
    input  logic              i_cfg_we,
    input  logic [12:0]       i_cfg_wdata,
    input  ffha_pkg::t_dp_cmd i_cmd,
    output ffha_pkg::t_dp_sts o_sts,
    output logic              o_done,
    output ffha_pkg::t_result o_result
);

    localparam int unsigned AW    = $clog2(HEAP_WORDS);
    // byte offsets reach the clamped length, at most 8192 from the 13-bit register
    localparam int unsigned OFF_W = (AW + 3 > 14) ? AW + 3 : 14;
    localparam int unsigned BUD_W = AW + 1;
    localparam int unsigned CAP   = HEAP_WORDS * 4;
    localparam logic [OFF_W-1:0] HDR = OFF_W'(ffha_pkg::HDR_BYTES);
    localparam logic [OFF_W-1:0] WRD = OFF_W'(4);

    logic [OFF_W-1:0] r_p, r_q, r_next, r_need, r_scan, r_eff_len;
    logic [11:0]      r_addr;
    logic [BUD_W-1:0] r_budget;
    logic             r_done;
    ffha_pkg::t_result r_result;

    logic [OFF_W-1:0] merged, tail, rem, addr_ext, off;
    logic [OFF_W:0]   need_hdr;
    logic [13:0]      need_rnd;
    logic [31:0]      wdata, rdata;
    logic             we;

    assign merged   = r_p - r_q - HDR;
    assign tail     = r_q + HDR + r_need;
    assign rem      = merged - r_need - HDR;
    assign need_hdr = {1'b0, r_need} + {1'b0, HDR};
    assign addr_ext = OFF_W'(r_addr);
    assign need_rnd = (14'(i_item.request_size) + 14'd3) & ~14'd3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan    <= '0;
            r_eff_len <= OFF_W'(ffha_pkg::eff_len(ffha_pkg::HEAP_LEN_RST, 32'(CAP)));
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_eff_len <= OFF_W'(ffha_pkg::eff_len(i_cfg_wdata, 32'(CAP)));
            end
            priority if (i_cmd.clear_scan) begin
                r_scan <= '0;
            end else if (i_cmd.set_scan_q) begin
                r_scan <= r_q;
            end else begin
                r_scan <= r_scan;
            end
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_alloc) begin
            r_p      <= r_scan;
            r_need   <= OFF_W'(need_rnd);
            r_budget <= BUD_W'(HEAP_WORDS);
        end else if (i_cmd.advance) begin
            r_p      <= r_next;
            r_budget <= r_budget - 1'b1;
        end
        if (i_cmd.mark_q) begin
            r_q <= r_p;
        end
        if (i_cmd.ld_free) begin
            r_addr <= i_item.block_address;
        end
        if (i_cmd.cap_next) begin
            r_next <= rdata[OFF_W-1:0];
        end
        if (i_cmd.finish) begin
            r_result.granted         <= i_cmd.grant;
            r_result.payload_address <= (i_cmd.grant && i_cmd.set_scan_q)
                                        ? 12'(r_q + HDR) : 12'd0;
        end
    end

    // Address and data per memory command
    always_comb begin
        off   = '0;
        wdata = '0;
        we    = 1'b0;
        unique case (i_cmd.mem_op)
            ffha_pkg::MEM_IDLE:    off = r_p;
            ffha_pkg::MEM_RD_NEXT: off = r_p;
            ffha_pkg::MEM_RD_SIZE: off = r_p + WRD;
            ffha_pkg::MEM_RD_FREE: off = addr_ext - WRD;
            ffha_pkg::MEM_WR_FMT_HEAD: begin
                off = '0;  wdata = 32'(r_eff_len - HDR);        we = 1'b1;
            end
            ffha_pkg::MEM_WR_FMT_SIZE: begin
                off = WRD; wdata = 32'(r_eff_len - HDR - HDR);  we = 1'b1;
            end
            ffha_pkg::MEM_WR_FMT_END: begin
                off = r_eff_len - HDR;                          we = 1'b1;
            end
            ffha_pkg::MEM_WR_FMT_END_SIZE: begin
                off = r_eff_len - WRD;                          we = 1'b1;
            end
            ffha_pkg::MEM_WR_RUN_SIZE: begin
                off = r_q + WRD; wdata = 32'(merged);           we = 1'b1;
            end
            ffha_pkg::MEM_WR_RUN_NEXT: begin
                off = r_q; wdata = 32'(r_p);                    we = 1'b1;
            end
            ffha_pkg::MEM_WR_USED_SIZE: begin
                off = r_q + WRD; wdata = 32'(r_need) | 32'd1;   we = 1'b1;
            end
            ffha_pkg::MEM_WR_SPLIT_NEXT: begin
                off = r_q; wdata = 32'(tail);                   we = 1'b1;
            end
            ffha_pkg::MEM_WR_TAIL_NEXT: begin
                off = tail; wdata = 32'(r_p);                   we = 1'b1;
            end
            ffha_pkg::MEM_WR_TAIL_SIZE: begin
                off = tail + WRD; wdata = 32'(rem);             we = 1'b1;
            end
            ffha_pkg::MEM_WR_FREE: begin
                off = addr_ext - WRD; wdata = rdata & ~32'd1;   we = 1'b1;
            end
            default: off = r_p;
        endcase
    end

    ffha_ram #(
        .WIDTH (32),
        .DEPTH (HEAP_WORDS)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (off[AW+1:2]),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    assign o_sts.next_zero  = (r_next == '0);
    assign o_sts.used       = rdata[0];
    assign o_sts.guard_fail = (r_next <= r_p) || (r_budget == '0);
    assign o_sts.fits       = ({1'b0, merged} >= need_hdr);
    assign o_sts.free_ok    = (r_addr >= 12'd8) && (r_addr[1:0] == 2'd0) &&
                              (addr_ext <= r_eff_len - HDR);

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_write_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && !i_cfg_we && !$past(i_cfg_we)) |-> (off < r_eff_len))
        else $error("heap write beyond usable length");
    a_walk_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> (r_next > r_p))
        else $error("walk advanced to a header that is not ahead");
    a_tail_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mem_op == ffha_pkg::MEM_WR_TAIL_NEXT) |-> (tail < r_p))
        else $error("split remainder header lies outside its run");
    a_zero_on_deny: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.granted) |-> (o_result.payload_address == 12'd0))
        else $error("payload address set on a denied request");
`endif

endmodule

@@ rtl/first_fit_heap_allocator_unit.sv @@
// First-fit heap allocator, top level: controller plus datapath.
// Depends on ffha_pkg, ffha_ctrl, ffha_dpath (which holds ffha_ram).
//
// Usage:
//   Command channel: an item (i_item) is taken at a clock edge with start high
//   and busy low. action 0 allocates request_size bytes (rounded up to four),
//   action 1 frees the block whose payload starts at block_address.
//   Result channel: o_done pulses for one cycle with o_result (granted and
//   payload_address); the receiver cannot hold it off.
//   Configuration: i_cfg_we with i_cfg_wdata writes heap_length while idle, a rule
//   only the user keeps; the heap is reformatted as one free block with busy high.
// Steps: for each header visited, an allocation reads the next and size words
//   and evaluates them; a run too small to split is written back merged (size,
//   then next) and its end header visited again; a split takes 4 writes, all
//   through the single RAM port. A free checks the address and, if valid, reads
//   and rewrites the size word. One item is in flight at a time; busy stays high
//   until its last state, and the strobe shows in the first cycle with busy low.
// Reset: control clears and the heap is formatted to 4096 bytes (or the RAM
//   size if smaller); busy stays high for the 4 format writes.
`timescale 1ns / 1ps

module first_fit_heap_allocator_unit #(
    parameter int unsigned HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ffha_pkg::t_item   i_item,
    output logic              o_done,
    output ffha_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic [12:0]       i_cfg_wdata
);

    ffha_pkg::t_dp_cmd cmd;
    ffha_pkg::t_dp_sts sts;

    ffha_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_item.action),
        .i_cfg_we (i_cfg_we),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    ffha_dpath #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule

@@ tb/first_fit_heap_allocator_unit_tb.sv @@
// Self-checking testbench for first_fit_heap_allocator_unit: a directed table, then random
// alloc/free traffic on several heap lengths, checked against the table or a local heap model.
// Depends on ffha_pkg and the RTL of first_fit_heap_allocator_unit.
`timescale 1ns / 1ps

module first_fit_heap_allocator_unit_tb;

    localparam int unsigned WORDS      = ffha_pkg::HEAP_WORDS_DEF;
    localparam int unsigned IDLE_LIMIT = 40000;
    localparam int unsigned N_PHASES   = 8;

    typedef struct packed {
        logic              is_cfg;
        logic [12:0]       cfg_val;
        ffha_pkg::t_item   item;
        logic              typed;
        ffha_pkg::t_result want;
    } t_stim_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    ffha_pkg::t_item   i_item      = '0;
    logic              o_done;
    ffha_pkg::t_result o_result;
    logic              i_cfg_we    = 1'b0;
    logic [12:0]       i_cfg_wdata = '0;

    // Local copy of the heap and allocator state
    logic [31:0] heap_img [0:WORDS-1];
    logic [31:0] rover;
    logic [12:0] heap_len_reg;

    ffha_pkg::t_result pending_results [$];
    logic [11:0]       live_blocks [$];
    t_stim_row         stim_rows [$];

    int unsigned errors     = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    int unsigned n_alloc    = 0;
    int unsigned n_grant    = 0;
    int unsigned n_free     = 0;
    int unsigned n_free_ok  = 0;
    int unsigned n_cfg      = 0;
    ffha_pkg::t_result head_result;

    first_fit_heap_allocator_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial forever #5 i_clk = ~i_clk;

    // ---------------- heap model ----------------

    function automatic logic [31:0] load_word(input logic [31:0] off);
        logic [31:0] w;
        w = off >> 2;
        return (w < WORDS) ? heap_img[w] : 32'd0;
    endfunction

    function automatic void store_word(input logic [31:0] off, input logic [31:0] v);
        logic [31:0] w;
        w = off >> 2;
        if (w < WORDS) heap_img[w] = v;
    endfunction

    function automatic logic [31:0] usable_len();
        logic [31:0] l;
        l = ({19'd0, heap_len_reg} + 32'd3) & ~32'd3;
        if (l > WORDS * 4) l = WORDS * 4;
        if (l < 32'd16) l = 32'd16;
        return l;
    endfunction

    // Lay out one free block plus the end marker; other words keep their contents.
    function automatic void format_heap(input logic [12:0] len_val);
        logic [31:0] len;
        logic [31:0] end_ofs;
        heap_len_reg = len_val;
        len     = usable_len();
        end_ofs = len - 32'd8;
        store_word(32'd0, end_ofs);
        store_word(32'd4, len - 32'd16);
        store_word(end_ofs, 32'd0);
        store_word(end_ofs + 32'd4, 32'd0);
        rover = 32'd0;
    endfunction

    function automatic logic [31:0] first_fit(input logic [31:0] req);
        logic [31:0] need;
        logic [31:0] budget;
        logic [31:0] p;
        logic [31:0] q;
        logic [31:0] n;
        logic [31:0] merged;
        logic [31:0] tail;
        need   = (req + 32'd3) & ~32'd3;
        budget = WORDS;
        p      = rover;
        while (1'b1) begin
            if (load_word(p) == 32'd0) return 32'd0;
            // skip used blocks
            while ((load_word(p + 32'd4) & 32'd1) != 32'd0) begin
                n = load_word(p);
                if (n <= p || budget == 0) return 32'd0;
                budget = budget - 1;
                p = n;
            end
            if (load_word(p) == 32'd0) return 32'd0;
            // merge the free run that starts at q
            q = p;
            while ((load_word(p + 32'd4) & 32'd1) == 32'd0 && load_word(p) != 32'd0) begin
                n = load_word(p);
                if (n <= p || budget == 0) return 32'd0;
                budget = budget - 1;
                p = n;
            end
            merged = p - q - 32'd8;
            store_word(q + 32'd4, merged);
            store_word(q, p);
            if (merged >= need + 32'd8) begin
                tail = q + 32'd8 + need;
                store_word(q, tail);
                store_word(q + 32'd4, need | 32'd1);
                store_word(tail, p);
                store_word(tail + 32'd4, merged - need - 32'd8);
                rover = q;
                return q + 32'd8;
            end
        end
        return 32'd0;
    endfunction

    function automatic ffha_pkg::t_result predict_result(input ffha_pkg::t_item it);
        ffha_pkg::t_result r;
        logic [31:0]       pay;
        logic [31:0]       addr;
        r    = '0;
        addr = {20'd0, it.block_address};
        if (it.action == ffha_pkg::ACT_ALLOC) begin
            pay = first_fit({19'd0, it.request_size});
            r.granted         = (pay != 32'd0);
            r.payload_address = pay[11:0];
        end else if (addr >= 32'd8 && addr[1:0] == 2'b00 && addr <= usable_len() - 32'd8) begin
            store_word(addr - 32'd4, load_word(addr - 32'd4) & ~32'd1);
            rover     = 32'd0;
            r.granted = 1'b1;
        end
        return r;
    endfunction

    // ---------------- checking ----------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with no item pending: granted %0d payload_address %0d",
                       o_result.granted, o_result.payload_address);
                errors++;
            end else begin
                head_result = pending_results.pop_front();
                if (o_result.granted !== head_result.granted) begin
                    $error("granted: expected %0d, got %0d",
                           head_result.granted, o_result.granted);
                    errors++;
                end
                if (o_result.payload_address !== head_result.payload_address) begin
                    $error("payload_address: expected %0d, got %0d",
                           head_result.payload_address, o_result.payload_address);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item or result for %0d cycles", IDLE_LIMIT);
                $display("FAIL first_fit_heap_allocator_unit");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic void row_item(input logic act, input logic [12:0] sz,
                                     input logic [11:0] addr, input logic typed,
                                     input logic g, input logic [11:0] pa);
        t_stim_row r;
        r = '0;
        r.item.action        = act;
        r.item.request_size  = sz;
        r.item.block_address = addr;
        r.typed              = typed;
        r.want.granted       = g;
        r.want.payload_address = pa;
        stim_rows.push_back(r);
    endfunction

    function automatic void row_cfg(input logic [12:0] v);
        t_stim_row r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        stim_rows.push_back(r);
    endfunction

    // Hold start and the item until the block takes it, then queue its result.
    task automatic send_item(input ffha_pkg::t_item it, input logic typed,
                             input ffha_pkg::t_result want,
                             output ffha_pkg::t_result got);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        got = predict_result(it);
        pending_results.push_back(typed ? want : got);
        if (it.action == ffha_pkg::ACT_ALLOC) begin
            n_alloc++;
            if (got.granted) n_grant++;
        end else begin
            n_free++;
            if (got.granted) n_free_ok++;
        end
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic after_item(input logic hold_off);
        int unsigned gap;
        if (hold_off) begin
            start <= 1'b0;
            drain_results();
        end else begin
            if (burst_left != 0) begin
                burst_left--;
                gap = 0;
            end else begin
                gap = $urandom_range(0, 12);
                if ($urandom_range(0, 24) == 0) burst_left = $urandom_range(10, 30);
            end
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Block must be idle with start low.
    task automatic write_heap_len(input logic [12:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        format_heap(v);
        live_blocks.delete();
        n_cfg++;
    endtask

    initial begin
        logic [12:0]       phase_len [N_PHASES];
        int unsigned       phase_cnt [N_PHASES];
        ffha_pkg::t_item   it;
        ffha_pkg::t_result got;
        t_stim_row         row;
        int unsigned       pick;
        int unsigned       idx;

        phase_len = '{13'd4096, 13'd200, 13'd0, 13'd1023, 13'd8191, 13'd17, 13'd2048, 13'd13};
        phase_cnt = '{300, 180, 30, 220, 260, 40, 330, 40};

        for (int i = 0; i < WORDS; i++) heap_img[i] = 32'd0;
        format_heap(ffha_pkg::HEAP_LEN_RST);

        // after reset: one free block of 4080 bytes at offset 0
        row_item(ffha_pkg::ACT_ALLOC, 13'd16,   12'd0,    1'b1, 1'b1, 12'd8);
        row_item(ffha_pkg::ACT_ALLOC, 13'd4096, 12'd0,    1'b1, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_ALLOC, 13'd8191, 12'd4095, 1'b1, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_FREE,  13'd0,    12'd0,    1'b1, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_FREE,  13'd8191, 12'd6,    1'b1, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_FREE,  13'd0,    12'd4092, 1'b1, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_FREE,  13'd0,    12'd4095, 1'b1, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_FREE,  13'd0,    12'd4,    1'b1, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_FREE,  13'd0,    12'd8,    1'b1, 1'b1, 12'd0);
        // top valid address: clears bit 0 of a payload word
        row_item(ffha_pkg::ACT_FREE,  13'd0,    12'd4088, 1'b1, 1'b1, 12'd0);
        row_item(ffha_pkg::ACT_ALLOC, 13'd1,    12'd0,    1'b0, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_ALLOC, 13'd3,    12'd0,    1'b0, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_ALLOC, 13'd0,    12'd0,    1'b0, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_ALLOC, 13'd100,  12'd0,    1'b0, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_FREE,  13'd0,    12'd20,   1'b0, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_ALLOC, 13'd4000, 12'd0,    1'b0, 1'b0, 12'd0);
        // exact fit leaves a zero-size tail, then nothing else fits
        row_cfg(13'd4096);
        row_item(ffha_pkg::ACT_ALLOC, 13'd4072, 12'd0,    1'b0, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_ALLOC, 13'd0,    12'd0,    1'b0, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_FREE,  13'd0,    12'd8,    1'b0, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_ALLOC, 13'd4073, 12'd0,    1'b0, 1'b0, 12'd0);
        // smallest heap: no allocation can be granted
        row_cfg(13'd16);
        row_item(ffha_pkg::ACT_ALLOC, 13'd0,    12'd0,    1'b1, 1'b0, 12'd0);
        row_item(ffha_pkg::ACT_FREE,  13'd0,    12'd8,    1'b1, 1'b1, 12'd0);
        row_item(ffha_pkg::ACT_FREE,  13'd0,    12'd12,   1'b1, 1'b0, 12'd0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < stim_rows.size(); i++) begin
            row = stim_rows[i];
            if (row.is_cfg) begin
                write_heap_len(row.cfg_val);
            end else begin
                send_item(row.item, row.typed, row.want, got);
                after_item(i + 1 == stim_rows.size() || stim_rows[i + 1].is_cfg);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_heap_len(phase_len[ph]);
            for (int k = 0; k < phase_cnt[ph]; k++) begin
                it   = '0;
                pick = $urandom_range(0, 99);
                if (live_blocks.size() > 30) pick = 60;
                if (pick >= 50 && pick < 85 && live_blocks.size() != 0) begin
                    // release a block that is still held
                    idx = $urandom_range(0, live_blocks.size() - 1);
                    it.action        = ffha_pkg::ACT_FREE;
                    it.block_address = live_blocks[idx];
                    it.request_size  = 13'($urandom_range(0, 8191));
                    live_blocks.delete(idx);
                end else if (pick >= 85) begin
                    it.action        = ffha_pkg::ACT_FREE;
                    it.block_address = 12'($urandom_range(0, 4095));
                    if ($urandom_range(0, 1)) it.block_address[1:0] = 2'b00;
                    it.request_size  = 13'($urandom_range(0, 8191));
                end else begin
                    it.action        = ffha_pkg::ACT_ALLOC;
                    it.block_address = 12'($urandom_range(0, 4095));
                    idx = $urandom_range(0, 9);
                    if (idx < 6)      it.request_size = 13'($urandom_range(0, 48));
                    else if (idx < 9) it.request_size = 13'($urandom_range(0, 300));
                    else              it.request_size = 13'($urandom_range(0, 8191));
                end
                send_item(it, 1'b0, '0, got);
                if (it.action == ffha_pkg::ACT_ALLOC && got.granted)
                    live_blocks.push_back(got.payload_address);
                after_item(k + 1 == phase_cnt[ph] || $urandom_range(0, 59) == 0);
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end

        $display("Ran %0d allocations (%0d granted) and %0d frees (%0d accepted)",
                 n_alloc, n_grant, n_free, n_free_ok);
        $display("across %0d heap length writes, %0d mismatches", n_cfg, errors);
        if (errors == 0) begin
            $display("PASS first_fit_heap_allocator_unit");
        end else begin
            $display("FAIL first_fit_heap_allocator_unit");
        end
        $finish;
    end

endmodule
